// ===== hw/rtl/csrg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package csrg_pkg;

    localparam int unsigned ID_W      = 11;
    localparam int unsigned LEN_W     = 2;
    localparam int unsigned MAX_RES   = 4;
    localparam int unsigned RES_CNT_W = 3;

    // received identifiers
    localparam logic [ID_W-1:0] ID_IN_DASH   = 11'h157;
    localparam logic [ID_W-1:0] ID_IN_MODES  = 11'h154;
    localparam logic [ID_W-1:0] ID_IN_1DC    = 11'h1DC;
    localparam logic [ID_W-1:0] ID_IN_193    = 11'h193;
    localparam logic [ID_W-1:0] ID_IN_15B    = 11'h15B;

    // emitted identifiers
    localparam logic [ID_W-1:0] ID_OUT_GEAR  = 11'h050;
    localparam logic [ID_W-1:0] ID_OUT_WHEEL_F = 11'h051;
    localparam logic [ID_W-1:0] ID_OUT_WHEEL_R = 11'h052;
    localparam logic [ID_W-1:0] ID_OUT_TC_ACT  = 11'h053;
    localparam logic [ID_W-1:0] ID_OUT_MAP     = 11'h100;
    localparam logic [ID_W-1:0] ID_OUT_TC      = 11'h101;
    localparam logic [ID_W-1:0] ID_OUT_WHEELIE = 11'h102;
    localparam logic [ID_W-1:0] ID_OUT_BRAKE   = 11'h103;

    localparam logic [LEN_W-1:0] LEN_ONE = 2'd1;
    localparam logic [LEN_W-1:0] LEN_TWO = 2'd2;

    localparam logic [7:0] MEMO_CLEAR = 8'hFF;

    // configuration register indexes
    localparam logic [1:0] CFG_REFRESH_PERIOD  = 2'd0;
    localparam logic [1:0] CFG_GEAR_LIMIT      = 2'd1;
    localparam logic [1:0] CFG_TC_THRESHOLD    = 2'd2;
    localparam logic [1:0] CFG_TC_ACTIVE_VALUE = 2'd3;

    typedef struct packed {
        logic [7:0]       byte1;
        logic [7:0]       byte0;
        logic [LEN_W-1:0] len;
        logic [ID_W-1:0]  id;
    } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/can_signal_remap_gateway.sv =====
`timescale 1ns / 1ps
`default_nettype none

// path: input register, then result buffer, then the master side
// throughput: one input transaction per cycle while m_axis_tready is high and each
// frame gives at most one result; n results (n <= 4) drain one per ready cycle
// reset: asynchronous active low; config registers return to 10/48/32/100,
// change memories to 255, refresh count to 0, both sides empty

module can_signal_remap_gateway
    import csrg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // frame_id, data_b0, data_b1, data_b2, data_b3, data_b4, data_b5, zero pad
    input  wire logic [63:0] s_axis_tdata,

    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_id, out_len, out_byte0, out_byte1, zero pad
    output      logic [31:0] m_axis_tdata,
    output      logic        m_axis_tlast,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata
);

    // configuration
    logic [7:0] refresh_period_reg;
    logic [7:0] gear_limit_reg;
    logic [7:0] tc_threshold_reg;
    logic [7:0] tc_active_value_reg;

    // change memories
    logic [7:0] gear_memo_reg, gear_memo_next;
    logic [7:0] map_memo_reg, map_memo_next;
    logic [7:0] tc_memo_reg, tc_memo_next;
    logic [7:0] wheelie_memo_reg, wheelie_memo_next;
    logic [7:0] brake_memo_reg, brake_memo_next;
    logic [7:0] refresh_count_reg, refresh_count_next;

    // input register
    logic            in_valid_reg, in_valid_next;
    logic [ID_W-1:0] in_id_reg;
    logic [7:0]      in_b_reg [6];

    // result buffer
    res_t                 res_reg [MAX_RES];
    res_t                 res_next [MAX_RES];
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;

    logic s_accept;
    logic m_take;
    logic buffer_free;
    logic consume;

    res_t                 cand [MAX_RES];
    logic [MAX_RES-1:0]   cand_v;
    res_t                 pack [MAX_RES];
    logic [RES_CNT_W-1:0] pack_n;

    logic [3:0] lo_nib;
    logic [3:0] hi_nib;
    logic [7:0] wheelie_val;
    logic [7:0] brake_val;
    logic [7:0] count_inc;
    logic       refresh_hit;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (res_cnt_reg != '0);
    assign m_take        = m_axis_tvalid && m_axis_tready;
    assign buffer_free   = (res_cnt_reg == '0) ||
                           ((res_cnt_reg == RES_CNT_W'(1)) && m_axis_tready);
    assign consume       = in_valid_reg && buffer_free;
    assign s_axis_tready = !in_valid_reg || buffer_free;

    assign m_axis_tdata  = {3'b000, res_reg[0]};
    assign m_axis_tlast  = (res_cnt_reg == RES_CNT_W'(1));

    // rider mode decode
    assign lo_nib = in_b_reg[2][3:0];
    assign hi_nib = in_b_reg[2][7:4];

    always_comb
    begin
        case (lo_nib)
            4'h4:    wheelie_val = 8'd1;
            4'h8:    wheelie_val = 8'd2;
            4'hC:    wheelie_val = 8'd3;
            default: wheelie_val = 8'd0;
        endcase
    end

    assign brake_val   = ((hi_nib >= 4'd1) && (hi_nib <= 4'd3)) ? {4'h0, hi_nib} : 8'd0;
    assign count_inc   = refresh_count_reg + 8'd1;
    assign refresh_hit = (count_inc >= refresh_period_reg);

    // candidate results and state update for the frame in the input register
    always_comb
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            cand[i] = '0;
        end
        cand_v             = '0;
        gear_memo_next     = gear_memo_reg;
        map_memo_next      = map_memo_reg;
        tc_memo_next       = tc_memo_reg;
        wheelie_memo_next  = wheelie_memo_reg;
        brake_memo_next    = brake_memo_reg;
        refresh_count_next = refresh_count_reg;

        case (in_id_reg)
            ID_IN_DASH:
            begin
                cand[0]   = '{byte1: 8'd0, byte0: {3'b000, in_b_reg[5][7:3]},
                              len: LEN_ONE, id: ID_OUT_GEAR};
                cand_v[0] = (in_b_reg[5] <= gear_limit_reg) && (in_b_reg[5] != gear_memo_reg);
                cand[1]   = '{byte1: in_b_reg[4], byte0: in_b_reg[3],
                              len: LEN_TWO, id: ID_OUT_WHEEL_F};
                cand_v[1] = 1'b1;
                cand[2]   = '{byte1: in_b_reg[2], byte0: in_b_reg[1],
                              len: LEN_TWO, id: ID_OUT_WHEEL_R};
                cand_v[2] = 1'b1;
                cand[3]   = '{byte1: 8'd0,
                              byte0: (in_b_reg[0] >= tc_threshold_reg) ?
                                     tc_active_value_reg : 8'd0,
                              len: LEN_ONE, id: ID_OUT_TC_ACT};
                cand_v[3] = 1'b1;
                if (consume && cand_v[0])
                begin
                    gear_memo_next = in_b_reg[5];
                end
            end
            ID_IN_1DC:
            begin
                cand[0]   = '{byte1: in_b_reg[3], byte0: in_b_reg[2],
                              len: LEN_TWO, id: ID_IN_1DC};
                cand_v[0] = 1'b1;
            end
            ID_IN_193:
            begin
                cand[0]   = '{byte1: in_b_reg[1], byte0: in_b_reg[0],
                              len: LEN_TWO, id: ID_IN_193};
                cand_v[0] = 1'b1;
            end
            ID_IN_15B:
            begin
                cand[0]   = '{byte1: in_b_reg[5], byte0: in_b_reg[4],
                              len: LEN_TWO, id: ID_IN_15B};
                cand_v[0] = 1'b1;
            end
            ID_IN_MODES:
            begin
                cand[0]   = '{byte1: 8'd0, byte0: {4'h0, in_b_reg[0][7:4]},
                              len: LEN_ONE, id: ID_OUT_MAP};
                cand_v[0] = (in_b_reg[0] != map_memo_reg);
                cand[1]   = '{byte1: 8'd0, byte0: {4'h0, in_b_reg[1][7:4]},
                              len: LEN_ONE, id: ID_OUT_TC};
                cand_v[1] = (in_b_reg[1] != tc_memo_reg);
                cand[2]   = '{byte1: 8'd0, byte0: wheelie_val,
                              len: LEN_ONE, id: ID_OUT_WHEELIE};
                cand_v[2] = (in_b_reg[2] != wheelie_memo_reg);
                cand[3]   = '{byte1: 8'd0, byte0: brake_val,
                              len: LEN_ONE, id: ID_OUT_BRAKE};
                cand_v[3] = (in_b_reg[2] != brake_memo_reg);
                if (consume)
                begin
                    if (refresh_hit)
                    begin
                        refresh_count_next = 8'd0;
                        gear_memo_next     = MEMO_CLEAR;
                        map_memo_next      = MEMO_CLEAR;
                        tc_memo_next       = MEMO_CLEAR;
                        wheelie_memo_next  = MEMO_CLEAR;
                        brake_memo_next    = MEMO_CLEAR;
                    end
                    else
                    begin
                        refresh_count_next = count_inc;
                        map_memo_next      = in_b_reg[0];
                        tc_memo_next       = in_b_reg[1];
                        wheelie_memo_next  = in_b_reg[2];
                        brake_memo_next    = in_b_reg[2];
                    end
                end
            end
            default:
            begin
                cand_v = '0;
            end
        endcase
    end

    // pack the sent results to the front
    always_comb
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            pack[i] = '0;
        end
        pack_n = '0;
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (cand_v[i])
            begin
                pack[pack_n[1:0]] = cand[i];
                pack_n            = pack_n + RES_CNT_W'(1);
            end
        end
    end

    // result buffer: load a whole frame or shift one result out
    always_comb
    begin
        res_next     = res_reg;
        res_cnt_next = res_cnt_reg;
        if (consume)
        begin
            res_next     = pack;
            res_cnt_next = pack_n;
        end
        else if (m_take)
        begin
            for (int i = 0; i < MAX_RES - 1; i++)
            begin
                res_next[i] = res_reg[i + 1];
            end
            res_cnt_next = res_cnt_reg - RES_CNT_W'(1);
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            res_cnt_reg       <= '0;
            gear_memo_reg     <= MEMO_CLEAR;
            map_memo_reg      <= MEMO_CLEAR;
            tc_memo_reg       <= MEMO_CLEAR;
            wheelie_memo_reg  <= MEMO_CLEAR;
            brake_memo_reg    <= MEMO_CLEAR;
            refresh_count_reg <= 8'd0;
        end
        else
        begin
            in_valid_reg      <= in_valid_next;
            res_cnt_reg       <= res_cnt_next;
            gear_memo_reg     <= gear_memo_next;
            map_memo_reg      <= map_memo_next;
            tc_memo_reg       <= tc_memo_next;
            wheelie_memo_reg  <= wheelie_memo_next;
            brake_memo_reg    <= brake_memo_next;
            refresh_count_reg <= refresh_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refresh_period_reg  <= 8'd10;
            gear_limit_reg      <= 8'd48;
            tc_threshold_reg    <= 8'd32;
            tc_active_value_reg <= 8'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_REFRESH_PERIOD:  refresh_period_reg  <= cfg_wdata;
                CFG_GEAR_LIMIT:      gear_limit_reg      <= cfg_wdata;
                CFG_TC_THRESHOLD:    tc_threshold_reg    <= cfg_wdata;
                CFG_TC_ACTIVE_VALUE: tc_active_value_reg <= cfg_wdata;
                default:             refresh_period_reg  <= refresh_period_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_id_reg <= s_axis_tdata[10:0];
            for (int i = 0; i < 6; i++)
            begin
                in_b_reg[i] <= s_axis_tdata[11 + 8*i +: 8];
            end
        end
        res_reg <= res_next;
    end

    // checks
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= RES_CNT_W'(MAX_RES))
        else $error("result count out of range");

    a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((res_reg[0].len == LEN_ONE && res_reg[0].byte1 == 8'd0) ||
                           res_reg[0].len == LEN_TWO))
        else $error("bad length or nonzero second byte");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !buffer_free) |=> (in_valid_reg && $stable(in_id_reg)))
        else $error("pending frame lost");

    a_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && in_id_reg == ID_IN_MODES && refresh_hit) |=>
            (refresh_count_reg == 8'd0 && map_memo_reg == MEMO_CLEAR &&
             gear_memo_reg == MEMO_CLEAR && brake_memo_reg == MEMO_CLEAR))
        else $error("refresh did not clear memories");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import csrg_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_FRAMES  = 66;
    localparam int HOLD_CYCLES   = 160;
    localparam int DIRECTED_ROWS = 20;

    typedef struct packed {
        logic last;
        res_t res;
    } out_frame_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [7:0]      b0;
        logic [7:0]      b1;
        logic [7:0]      b2;
        logic [7:0]      b3;
        logic [7:0]      b4;
        logic [7:0]      b5;
        logic            typed;
        logic            want_one;
        logic [7:0]      want0;
        logic [7:0]      want1;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [31:0] m_axis_tdata;
    wire         m_axis_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = CFG_REFRESH_PERIOD;
    logic [7:0]  cfg_wdata = '0;

    logic steady = 1'b0;
    logic hold_go = 1'b0;
    bit   hold_taken = 1'b0;
    int   hold_left = 0;
    int   errors = 0;
    int   cycle_count = 0;

    // gateway model state
    logic [7:0] resend_period;
    logic [7:0] gear_max;
    logic [7:0] tc_on_level;
    logic [7:0] tc_on_byte;
    logic [7:0] gear_memo;
    logic [7:0] map_memo;
    logic [7:0] tc_memo;
    logic [7:0] wheelie_memo;
    logic [7:0] brake_memo;
    logic [7:0] modes_seen;

    out_frame_t remap_expected [$];
    out_frame_t fresh [$];

    logic [7:0] last_gear = 8'h00;
    logic [7:0] last_modes [3] = '{8'h00, 8'h00, 8'h00};

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{11'h000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00},
        '{11'h7FF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00, 8'h00},
        '{ID_IN_1DC, 8'h01, 8'h02, 8'hA5, 8'h5A, 8'h03, 8'h04, 1'b1, 1'b1, 8'hA5, 8'h5A},
        '{ID_IN_193, 8'hFF, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 1'b1, 1'b1, 8'hFF, 8'h00},
        '{ID_IN_15B, 8'h55, 8'h66, 8'h77, 8'h88, 8'h00, 8'hFF, 1'b1, 1'b1, 8'h00, 8'hFF},
        '{ID_IN_DASH, 8'h20, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h30, 1'b0, 1'b0, 8'h00, 8'h00},
        '{ID_IN_DASH, 8'h1F, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h30, 1'b0, 1'b0, 8'h00, 8'h00},
        '{ID_IN_DASH, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78, 8'h31, 1'b0, 1'b0, 8'h00, 8'h00},
        '{ID_IN_DASH, 8'h00, 8'hAB, 8'hCD, 8'hEF, 8'h01, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00},
        '{ID_IN_MODES, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00},
        '{ID_IN_MODES, 8'h37, 8'h52, 8'h34, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00},
        '{ID_IN_MODES, 8'h37, 8'h52, 8'h34, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
        '{ID_IN_MODES, 8'h00, 8'hF0, 8'h84, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00},
        '{ID_IN_MODES, 8'h10, 8'hF0, 8'hC2, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00},
        '{ID_IN_MODES, 8'h10, 8'hF0, 8'h18, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00},
        '{ID_IN_MODES, 8'h10, 8'hF0, 8'h2C, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00},
        '{ID_IN_MODES, 8'h20, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00},
        '{ID_IN_MODES, 8'h20, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00},
        '{ID_IN_MODES, 8'h20, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00},
        '{ID_IN_MODES, 8'h20, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00}
    };

    can_signal_remap_gateway uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("can_signal_remap_gateway regression: fail");
            $finish;
        end
    end

    function automatic out_frame_t make_out(input logic [ID_W-1:0] id,
                                            input logic [LEN_W-1:0] len,
                                            input logic [7:0] lo_byte,
                                            input logic [7:0] hi_byte);
        out_frame_t f;
        f.res.id    = id;
        f.res.len   = len;
        f.res.byte0 = lo_byte;
        f.res.byte1 = hi_byte;
        f.last      = 1'b0;
        return f;
    endfunction

    task automatic clear_memos();
        gear_memo    = MEMO_CLEAR;
        map_memo     = MEMO_CLEAR;
        tc_memo      = MEMO_CLEAR;
        wheelie_memo = MEMO_CLEAR;
        brake_memo   = MEMO_CLEAR;
    endtask

    // remapped frames caused by one received frame, left in fresh
    task automatic remap_predict(input logic [63:0] word);
        logic [ID_W-1:0] fid;
        logic [7:0]      d [6];
        logic [3:0]      lo;
        logic [3:0]      hi;
        logic [7:0]      wv;
        logic [7:0]      ev;
        int              k;
        fid = word[ID_W-1:0];
        for (k = 0; k < 6; k++)
            d[k] = word[ID_W + 8*k +: 8];
        fresh.delete();
        case (fid)
            ID_IN_DASH:
            begin
                if (d[5] <= gear_max && d[5] != gear_memo)
                begin
                    gear_memo = d[5];
                    fresh.push_back(make_out(ID_OUT_GEAR, LEN_ONE, d[5] >> 3, 8'h00));
                end
                fresh.push_back(make_out(ID_OUT_WHEEL_F, LEN_TWO, d[3], d[4]));
                fresh.push_back(make_out(ID_OUT_WHEEL_R, LEN_TWO, d[1], d[2]));
                fresh.push_back(make_out(ID_OUT_TC_ACT, LEN_ONE,
                                         (d[0] >= tc_on_level) ? tc_on_byte : 8'h00, 8'h00));
            end
            ID_IN_1DC: fresh.push_back(make_out(ID_IN_1DC, LEN_TWO, d[2], d[3]));
            ID_IN_193: fresh.push_back(make_out(ID_IN_193, LEN_TWO, d[0], d[1]));
            ID_IN_15B: fresh.push_back(make_out(ID_IN_15B, LEN_TWO, d[4], d[5]));
            ID_IN_MODES:
            begin
                lo = d[2][3:0];
                hi = d[2][7:4];
                case (lo)
                    4'h4:    wv = 8'd1;
                    4'h8:    wv = 8'd2;
                    4'hC:    wv = 8'd3;
                    default: wv = 8'd0;
                endcase
                ev = (hi >= 4'd1 && hi <= 4'd3) ? {4'h0, hi} : 8'd0;
                if (d[0] != map_memo)
                begin
                    map_memo = d[0];
                    fresh.push_back(make_out(ID_OUT_MAP, LEN_ONE, {4'h0, d[0][7:4]}, 8'h00));
                end
                if (d[1] != tc_memo)
                begin
                    tc_memo = d[1];
                    fresh.push_back(make_out(ID_OUT_TC, LEN_ONE, {4'h0, d[1][7:4]}, 8'h00));
                end
                if (d[2] != wheelie_memo)
                begin
                    wheelie_memo = d[2];
                    fresh.push_back(make_out(ID_OUT_WHEELIE, LEN_ONE, wv, 8'h00));
                end
                if (d[2] != brake_memo)
                begin
                    brake_memo = d[2];
                    fresh.push_back(make_out(ID_OUT_BRAKE, LEN_ONE, ev, 8'h00));
                end
                modes_seen = modes_seen + 8'd1;
                if (modes_seen >= resend_period)
                begin
                    modes_seen = 8'd0;
                    clear_memos();
                end
            end
            default: ;
        endcase
        if (fresh.size() > 0)
            fresh[fresh.size()-1].last = 1'b1;
    endtask

    function automatic logic [63:0] random_frame();
        logic [ID_W-1:0] fid;
        logic [7:0]      d [6];
        logic [1:0]      hsel;
        logic [1:0]      lsel;
        logic [63:0]     w;
        int              pick;
        int              k;
        for (k = 0; k < 6; k++)
            d[k] = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            fid = ID_IN_DASH;
            case ($urandom_range(0, 3))
                0:       d[5] = last_gear;
                1, 2:    d[5] = 8'($urandom_range(0, 63));
                default: ;
            endcase
            last_gear = d[5];
        end
        else if (pick < 60)
        begin
            fid = ID_IN_MODES;
            // settings are often repeated from the last modes frame so that change gating is exercised
            for (k = 0; k < 3; k++)
                if ($urandom_range(0, 1))
                    d[k] = last_modes[k];
            if ($urandom_range(0, 2) == 0)
            begin
                hsel = 2'($urandom_range(0, 3));
                lsel = 2'($urandom_range(0, 3));
                d[2] = {2'b00, hsel, lsel, 2'b00};
            end
            if ($urandom_range(0, 9) == 0)
            begin
                d[0] = MEMO_CLEAR;
                d[1] = MEMO_CLEAR;
                d[2] = MEMO_CLEAR;
            end
            for (k = 0; k < 3; k++)
                last_modes[k] = d[k];
        end
        else if (pick < 68)
            fid = ID_IN_1DC;
        else if (pick < 76)
            fid = ID_IN_193;
        else if (pick < 84)
            fid = ID_IN_15B;
        else if ($urandom_range(0, 1))
            fid = ID_IN_DASH ^ (11'h001 << $urandom_range(0, 10));
        else
            fid = ID_W'($urandom_range(0, 2047));
        w = '0;
        w[ID_W-1:0] = fid;
        for (k = 0; k < 6; k++)
            w[ID_W + 8*k +: 8] = d[k];
        return w;
    endfunction

    task automatic send_frame(input logic [63:0] word, input logic typed,
                              input logic want_one, input out_frame_t want);
        while (!steady && $urandom_range(0, 99) < 25)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        remap_predict(word);
        if (typed)
        begin
            if (want_one)
                remap_expected.push_back(want);
        end
        else
            foreach (fresh[k])
                remap_expected.push_back(fresh[k]);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (remap_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic [7:0] period, input logic [7:0] limit,
                                  input logic [7:0] level, input logic [7:0] onbyte);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_REFRESH_PERIOD;
        cfg_wdata <= period;
        @(posedge clk);
        cfg_addr  <= CFG_GEAR_LIMIT;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_addr  <= CFG_TC_THRESHOLD;
        cfg_wdata <= level;
        @(posedge clk);
        cfg_addr  <= CFG_TC_ACTIVE_VALUE;
        cfg_wdata <= onbyte;
        @(posedge clk);
        cfg_we <= 1'b0;
        resend_period = period;
        gear_max      = limit;
        tc_on_level   = level;
        tc_on_byte    = onbyte;
    endtask

    // result side: random back-pressure (ready held high in the steady phase) plus one long hold-off
    always @(posedge clk)
    begin : result_check
        out_frame_t want;
        out_frame_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.res  = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
            got.last = m_axis_tlast;
            if (remap_expected.size() == 0)
            begin
                $display("%0t: unexpected transaction, actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                errors++;
            end
            else
            begin
                want = remap_expected.pop_front();
                if (got.res.id != want.res.id)
                begin
                    $display("%0t: out_id expected %h actual %h", $time, want.res.id, got.res.id);
                    errors++;
                end
                if (got.res.len != want.res.len)
                begin
                    $display("%0t: out_len expected %0d actual %0d",
                             $time, want.res.len, got.res.len);
                    errors++;
                end
                if (got.res.byte0 != want.res.byte0)
                begin
                    $display("%0t: out_byte0 expected %h actual %h",
                             $time, want.res.byte0, got.res.byte0);
                    errors++;
                end
                if (got.res.byte1 != want.res.byte1)
                begin
                    $display("%0t: out_byte1 expected %h actual %h",
                             $time, want.res.byte1, got.res.byte1);
                    errors++;
                end
                if (got.last != want.last)
                begin
                    $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                    errors++;
                end
            end
        end
        if (hold_go && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (steady)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= 25);
    end

    initial
    begin : stimulus
        stim_row_t   row;
        out_frame_t  want;
        logic [63:0] word;
        int          k;
        int          ph;
        int          known;
        resend_period = 8'd10;
        gear_max      = 8'd48;
        tc_on_level   = 8'd32;
        tc_on_byte    = 8'd100;
        modes_seen    = 8'd0;
        clear_memos();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIRECTED_ROWS; k++)
        begin
            row  = directed_rows[k];
            word = {5'b0, row.b5, row.b4, row.b3, row.b2, row.b1, row.b0, row.id};
            want = make_out(row.id, LEN_TWO, row.want0, row.want1);
            want.last = 1'b1;
            send_frame(word, row.typed, row.want_one, want);
        end

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_settings(8'd1, 8'd0, 8'd0, 8'd0);
                1: write_settings(8'd0, 8'd40, 8'd128, 8'd200);
                2: write_settings(8'd255, 8'd255, 8'd255, 8'd255);
                3: write_settings(8'd3, 8'd20, 8'd200, 8'd7);
                4: write_settings(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                default: write_settings(8'd10, 8'd48, 8'd32, 8'd100);
            endcase
            steady <= (ph == 4);
            if (ph == 2)
                hold_go <= 1'b1;
            known = 0;
            while (known < PHASE_FRAMES)
            begin
                word = random_frame();
                send_frame(word, 1'b0, 1'b0, '0);
                if (word[ID_W-1:0] inside {ID_IN_DASH, ID_IN_MODES, ID_IN_1DC,
                                           ID_IN_193, ID_IN_15B})
                    known++;
            end
        end

        drain_results();
        if (errors == 0)
            $display("can_signal_remap_gateway regression: pass");
        else
            $display("can_signal_remap_gateway regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/csrg_pkg.sv
hw/rtl/can_signal_remap_gateway.sv
tb/tb.sv
